// ===== rtl/sender_allowlist_rate_filter_core_assert.svh =====
// Assertion macros for the sender allowlist rate filter checker.
`ifndef SENDER_ALLOWLIST_RATE_FILTER_CORE_ASSERT_SVH
`define SENDER_ALLOWLIST_RATE_FILTER_CORE_ASSERT_SVH

// Check a property on every rising edge while out of reset.
`define SARF_AST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sarf assertion failed");

// Check a property on every rising edge, reset included.
`define SARF_AST_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sarf assertion failed");

`endif

// ===== rtl/sarf_pkg.sv =====
// Shared types and constants of the sender allowlist rate filter.
`default_nettype none
package sarf_pkg;

    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W = 64;
    localparam int IN_TUSER_W = 3;
    localparam int OUT_TDATA_W = 8;

    // Command codes
    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REVOKE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DENIED = 2'd1;
    localparam logic [1:0] ST_RATE   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Result of the shared compare/subtract unit
    typedef struct packed {
        logic              eq;
        logic              lt;
        logic [DATA_W-1:0] diff;
    } alu_res_t;

endpackage
`default_nettype wire

// ===== rtl/sarf_alu.sv =====
// Shared compare and subtract unit: equality, unsigned less-than, difference.
`default_nettype none
module sarf_alu (
    input  wire logic [sarf_pkg::DATA_W-1:0] a,
    input  wire logic [sarf_pkg::DATA_W-1:0] b,
    output sarf_pkg::alu_res_t               res
);

    logic [sarf_pkg::DATA_W:0] sub;

    // One subtractor gives both the wrapped difference and the borrow.
    assign sub      = {1'b0, a} - {1'b0, b};
    assign res.diff = sub[sarf_pkg::DATA_W-1:0];
    assign res.lt   = sub[sarf_pkg::DATA_W];
    assign res.eq   = (a == b);

endmodule
`default_nettype wire

// ===== rtl/sarf_table.sv =====
// Small table memory with per-entry valid bits and a registered read port.
`default_nettype none
module sarf_table #(
    parameter int DEPTH = 8
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_idx,
    input  wire logic [sarf_pkg::DATA_W-1:0]                   wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_idx,
    output logic      [sarf_pkg::DATA_W-1:0]                   rd_data
);

    logic [sarf_pkg::DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [sarf_pkg::DATA_W-1:0] rd_data_reg;

    // An entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_idx] ? mem[rd_idx] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/sender_allowlist_rate_filter_core.sv =====
// Top level of the sender allowlist rate filter: sequencer, tables and result register.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  tdata: node_id, now_ms; tuser: cmd, is_new_report
//  m_*       out  m_tvalid/m_tready  tdata: ok, status (zero padded to 8 bits)
//  cfg_*     in   cfg_we             cfg_wdata: min_interval_ms
//
// One beat at a time: accept, a scan of the allowlist unless the id is zero or the command
// is unused, then for a new report of a listed sender on a check a scan of the rate ids and
// either a scan for the oldest time or a read, subtract and compare to check the elapsed
// time, then posting of the result, with one table entry read per cycle in each scan.
// Reset is synchronous, active low, and empties all tables; no clearing pass.
// A waiting result does not block accept; a finished beat holds until m_tready.
`default_nettype none
module sender_allowlist_rate_filter_core #(
    parameter int ALLOW_DEPTH = 8,
    parameter int RATE_DEPTH  = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input beats
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [sarf_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] node_id, [63:32] now_ms
    input  wire logic [sarf_pkg::IN_TUSER_W-1:0]     s_tuser,  // [1:0] cmd, [2] is_new_report
    // result beats
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [sarf_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [0] ok, [2:1] status, [7:3] zero
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [sarf_pkg::DATA_W-1:0]         cfg_wdata // min_interval_ms
);

    localparam int AIW  = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
    localparam int RIW  = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
    localparam int MAXD = (ALLOW_DEPTH > RATE_DEPTH) ? ALLOW_DEPTH : RATE_DEPTH;
    localparam int MIW  = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int SCW  = $clog2(MAXD + 1);
    localparam int DW   = sarf_pkg::DATA_W;

    localparam logic [DW-1:0] INTERVAL_RESET = 32'd60000;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ASCAN    = 3'd1;
    localparam logic [2:0] S_RSCAN_ID = 3'd2;
    localparam logic [2:0] S_RSCAN_TM = 3'd3;
    localparam logic [2:0] S_RREAD    = 3'd4;
    localparam logic [2:0] S_RSUB     = 3'd5;
    localparam logic [2:0] S_RCMP     = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    // Control registers
    logic [2:0]     state_reg, state_next;
    logic [SCW-1:0] cnt_reg, cnt_next;
    logic           pvld_reg, pvld_next;
    logic           found_reg, found_next;
    logic           empty_found_reg, empty_found_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]  interval_reg;

    // Payload registers
    logic [1:0]     cmd_reg, cmd_next;
    logic [DW-1:0]  id_reg, id_next;
    logic           fresh_reg, fresh_next;
    logic [DW-1:0]  now_reg, now_next;
    logic [MIW-1:0] pidx_reg, pidx_next;
    logic [MIW-1:0] found_idx_reg, found_idx_next;
    logic [AIW-1:0] empty_idx_reg, empty_idx_next;
    logic [DW-1:0]  least_reg, least_next;
    logic [RIW-1:0] pick_reg, pick_next;
    logic [DW-1:0]  diff_reg, diff_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [1:0]     m_status_reg, m_status_next;
    logic           m_ok_reg, m_ok_next;

    // Table ports
    logic           al_wr_en, al_rd_en;
    logic [AIW-1:0] al_wr_idx, al_rd_idx;
    logic [DW-1:0]  al_wr_data, al_rd_data;
    logic           ri_wr_en, ri_rd_en;
    logic [RIW-1:0] ri_wr_idx, ri_rd_idx;
    logic [DW-1:0]  ri_wr_data, ri_rd_data;
    logic           rt_wr_en, rt_rd_en;
    logic [RIW-1:0] rt_wr_idx, rt_rd_idx;
    logic [DW-1:0]  rt_wr_data, rt_rd_data;

    // Shared unit
    logic [DW-1:0]       alu_a, alu_b;
    sarf_pkg::alu_res_t  alu_res;

    logic [1:0] in_cmd;
    logic [DW-1:0] in_id;

    assign in_cmd = s_tuser[1:0];
    assign in_id  = s_tdata[DW-1:0];

    sarf_table #(.DEPTH(ALLOW_DEPTH)) u_allow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (al_wr_en),
        .wr_idx  (al_wr_idx),
        .wr_data (al_wr_data),
        .rd_en   (al_rd_en),
        .rd_idx  (al_rd_idx),
        .rd_data (al_rd_data)
    );

    sarf_table #(.DEPTH(RATE_DEPTH)) u_rate_ids (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ri_wr_en),
        .wr_idx  (ri_wr_idx),
        .wr_data (ri_wr_data),
        .rd_en   (ri_rd_en),
        .rd_idx  (ri_rd_idx),
        .rd_data (ri_rd_data)
    );

    sarf_table #(.DEPTH(RATE_DEPTH)) u_rate_times (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (rt_wr_en),
        .wr_idx  (rt_wr_idx),
        .wr_data (rt_wr_data),
        .rd_en   (rt_rd_en),
        .rd_idx  (rt_rd_idx),
        .rd_data (rt_rd_data)
    );

    sarf_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(sarf_pkg::OUT_TDATA_W-3){1'b0}}, m_status_reg, m_ok_reg};

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pvld_next        = pvld_reg;
        found_next       = found_reg;
        empty_found_next = empty_found_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        fresh_next       = fresh_reg;
        now_next         = now_reg;
        pidx_next        = pidx_reg;
        found_idx_next   = found_idx_reg;
        empty_idx_next   = empty_idx_reg;
        least_next       = least_reg;
        pick_next        = pick_reg;
        diff_next        = diff_reg;
        res_status_next  = res_status_reg;
        m_status_next    = m_status_reg;
        m_ok_next        = m_ok_reg;
        // drop the result beat once taken
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        al_wr_en   = 1'b0;
        al_wr_idx  = empty_idx_reg;
        al_wr_data = id_reg;
        al_rd_en   = 1'b0;
        al_rd_idx  = cnt_reg[AIW-1:0];
        ri_wr_en   = 1'b0;
        ri_wr_idx  = pick_reg;
        ri_wr_data = id_reg;
        ri_rd_en   = 1'b0;
        ri_rd_idx  = cnt_reg[RIW-1:0];
        rt_wr_en   = 1'b0;
        rt_wr_idx  = pick_reg;
        rt_wr_data = now_reg;
        rt_rd_en   = 1'b0;
        rt_rd_idx  = cnt_reg[RIW-1:0];

        alu_a = al_rd_data;
        alu_b = id_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next         = in_cmd;
                    id_next          = in_id;
                    fresh_next       = s_tuser[2];
                    now_next         = s_tdata[2*DW-1:DW];
                    cnt_next         = '0;
                    pvld_next        = 1'b0;
                    found_next       = 1'b0;
                    empty_found_next = 1'b0;
                    // reserved id and unused command go straight to a deny
                    if (in_id == '0 ||
                        (in_cmd != sarf_pkg::CMD_CHECK && in_cmd != sarf_pkg::CMD_ADD &&
                         in_cmd != sarf_pkg::CMD_REVOKE)) begin
                        res_status_next = sarf_pkg::ST_DENIED;
                        state_next      = S_FINISH;
                    end else begin
                        state_next = S_ASCAN;
                    end
                end
            end

            S_ASCAN: begin
                // issue one read per cycle, compare the entry from the previous read once it is registered
                if (cnt_reg < SCW'(ALLOW_DEPTH)) begin
                    al_rd_en  = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[MIW-1:0];
                end else begin
                    pvld_next = 1'b0;
                end
                if (pvld_reg) begin
                    if (alu_res.eq && !found_reg) begin
                        found_next     = 1'b1;
                        found_idx_next = pidx_reg;
                    end
                    if (al_rd_data == '0 && !empty_found_reg) begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = pidx_reg[AIW-1:0];
                    end
                end
                if (!(cnt_reg < SCW'(ALLOW_DEPTH)) && !pvld_reg) begin
                    state_next = S_FINISH;
                    case (cmd_reg)
                        sarf_pkg::CMD_CHECK: begin
                            if (!found_reg) begin
                                res_status_next = sarf_pkg::ST_DENIED;
                            end else if (!fresh_reg) begin
                                res_status_next = sarf_pkg::ST_OK;
                            end else begin
                                state_next = S_RSCAN_ID;
                                cnt_next   = '0;
                                found_next = 1'b0;
                            end
                        end
                        sarf_pkg::CMD_ADD: begin
                            if (found_reg) begin
                                res_status_next = sarf_pkg::ST_OK;
                            end else if (empty_found_reg) begin
                                al_wr_en        = 1'b1;
                                res_status_next = sarf_pkg::ST_OK;
                            end else begin
                                res_status_next = sarf_pkg::ST_FULL;
                            end
                        end
                        sarf_pkg::CMD_REVOKE: begin
                            if (found_reg) begin
                                al_wr_en        = 1'b1;
                                al_wr_idx       = found_idx_reg[AIW-1:0];
                                al_wr_data      = '0;
                                res_status_next = sarf_pkg::ST_OK;
                            end else begin
                                res_status_next = sarf_pkg::ST_DENIED;
                            end
                        end
                        default: begin
                            res_status_next = sarf_pkg::ST_DENIED;
                        end
                    endcase
                end
            end

            S_RSCAN_ID: begin
                alu_a = ri_rd_data;
                if (cnt_reg < SCW'(RATE_DEPTH)) begin
                    ri_rd_en  = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[MIW-1:0];
                end else begin
                    pvld_next = 1'b0;
                end
                if (pvld_reg && alu_res.eq && !found_reg) begin
                    found_next     = 1'b1;
                    found_idx_next = pidx_reg;
                end
                if (!(cnt_reg < SCW'(RATE_DEPTH)) && !pvld_reg) begin
                    if (found_reg) begin
                        state_next = S_RREAD;
                    end else begin
                        state_next = S_RSCAN_TM;
                        cnt_next   = '0;
                        least_next = '1;
                        pick_next  = '0;
                    end
                end
            end

            S_RSCAN_TM: begin
                // keep the first slot with the strictly smallest time
                alu_a = rt_rd_data;
                alu_b = least_reg;
                if (cnt_reg < SCW'(RATE_DEPTH)) begin
                    rt_rd_en  = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pvld_next = 1'b1;
                    pidx_next = cnt_reg[MIW-1:0];
                end else begin
                    pvld_next = 1'b0;
                end
                if (pvld_reg && alu_res.lt) begin
                    least_next = rt_rd_data;
                    pick_next  = pidx_reg[RIW-1:0];
                end
                if (!(cnt_reg < SCW'(RATE_DEPTH)) && !pvld_reg) begin
                    // evicted slot is treated as never accepted, so the report is taken and its time stored
                    ri_wr_en        = 1'b1;
                    rt_wr_en        = 1'b1;
                    res_status_next = sarf_pkg::ST_OK;
                    state_next      = S_FINISH;
                end
            end

            S_RREAD: begin
                rt_rd_en   = 1'b1;
                rt_rd_idx  = found_idx_reg[RIW-1:0];
                state_next = S_RSUB;
            end

            S_RSUB: begin
                alu_a = now_reg;
                alu_b = rt_rd_data;
                if (rt_rd_data == '0) begin
                    rt_wr_en        = 1'b1;
                    rt_wr_idx       = found_idx_reg[RIW-1:0];
                    res_status_next = sarf_pkg::ST_OK;
                    state_next      = S_FINISH;
                end else begin
                    diff_next  = alu_res.diff;
                    state_next = S_RCMP;
                end
            end

            S_RCMP: begin
                alu_a      = diff_reg;
                alu_b      = interval_reg;
                state_next = S_FINISH;
                if (alu_res.lt) begin
                    res_status_next = sarf_pkg::ST_RATE;
                end else begin
                    rt_wr_en        = 1'b1;
                    rt_wr_idx       = found_idx_reg[RIW-1:0];
                    res_status_next = sarf_pkg::ST_OK;
                end
            end

            S_FINISH: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_ok_next     = (res_status_reg == sarf_pkg::ST_OK);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            pvld_reg        <= 1'b0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            interval_reg    <= INTERVAL_RESET;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pvld_reg        <= pvld_next;
            found_reg       <= found_next;
            empty_found_reg <= empty_found_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_we) begin
                interval_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        fresh_reg      <= fresh_next;
        now_reg        <= now_next;
        pidx_reg       <= pidx_next;
        found_idx_reg  <= found_idx_next;
        empty_idx_reg  <= empty_idx_next;
        least_reg      <= least_next;
        pick_reg       <= pick_next;
        diff_reg       <= diff_next;
        res_status_reg <= res_status_next;
        m_status_reg   <= m_status_next;
        m_ok_reg       <= m_ok_next;
    end

endmodule
`default_nettype wire

// ===== rtl/sarf_checker.sv =====
// Port-level checker for the sender allowlist rate filter, bound to the top level.
`default_nettype none
`include "sender_allowlist_rate_filter_core_assert.svh"
module sarf_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [sarf_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    `SARF_AST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // reset empties the result register
    `SARF_AST_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_tvalid)
    // ok is set exactly for the ok status
    `SARF_AST(a_ok_status, aclk, aresetn, m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == 2'd0)))
    // one beat at a time: no accept right after an accept
    `SARF_AST(a_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    // padding bits stay zero
    `SARF_AST(a_pad, aclk, aresetn, m_tvalid |-> (m_tdata[7:3] == 5'd0))

endmodule

bind sender_allowlist_rate_filter_core sarf_checker u_sarf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== verif/sender_allowlist_rate_filter_core_tb.sv =====
// Self-checking testbench for the sender allowlist rate filter: stimulus, predictor, checks.
`default_nettype none
module sender_allowlist_rate_filter_core_tb;

    localparam int ALLOW_N = 8;
    localparam int RATE_N = 8;
    localparam int POOL_N = 12;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int PHASES = 7;
    // worst-case cycles for one beat, taken twice for the final drain
    localparam int DRAIN_CYCLES = 2 * (ALLOW_N + 2 * RATE_N + 8);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTED = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [31:0] INTERVAL_AT_RESET = 32'd60000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] id;
        logic        fresh;
        logic [31:0] now;
    } filter_req_t;

    // Mirror of the allowlist and rate slots; predicts one status per accepted beat.
    class admission_predictor;
        logic [31:0] interval;
        logic [31:0] allow_ids[ALLOW_N];
        logic [31:0] rate_ids[RATE_N];
        logic [31:0] rate_times[RATE_N];
        logic [1:0]  verdict_q[$];
        int          errors;
        int          cmd_seen[4];
        int          verdict_seen[4];

        function new();
            interval = INTERVAL_AT_RESET;
            allow_ids = '{default: '0};
            rate_ids = '{default: '0};
            rate_times = '{default: '0};
            errors = 0;
            cmd_seen = '{default: 0};
            verdict_seen = '{default: 0};
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void note_request(filter_req_t r);
            int          i;
            int          slot;
            bit          hit;
            logic [31:0] least;
            logic [1:0]  st;
            st = sarf_pkg::ST_DENIED;
            cmd_seen[r.cmd]++;
            if (r.id != '0) begin
                case (r.cmd)
                    sarf_pkg::CMD_CHECK: begin
                        hit = 1'b0;
                        for (i = 0; i < ALLOW_N; i++)
                            if (allow_ids[i] == r.id) hit = 1'b1;
                        if (hit && !r.fresh) begin
                            st = sarf_pkg::ST_OK;
                        end else if (hit) begin
                            // find the sender's slot, else evict the first oldest one
                            slot = 0;
                            least = '1;
                            hit = 1'b0;
                            for (i = 0; i < RATE_N; i++) begin
                                if (!hit) begin
                                    if (rate_ids[i] == r.id) begin
                                        slot = i;
                                        hit = 1'b1;
                                    end else if (rate_times[i] < least) begin
                                        least = rate_times[i];
                                        slot = i;
                                    end
                                end
                            end
                            if (!hit) begin
                                rate_ids[slot] = r.id;
                                rate_times[slot] = '0;
                            end
                            // a stored time of zero means never accepted
                            if (rate_times[slot] != '0 && r.now - rate_times[slot] < interval) begin
                                st = sarf_pkg::ST_RATE;
                            end else begin
                                rate_times[slot] = r.now;
                                st = sarf_pkg::ST_OK;
                            end
                        end
                    end
                    sarf_pkg::CMD_ADD: begin
                        hit = 1'b0;
                        for (i = 0; i < ALLOW_N; i++)
                            if (allow_ids[i] == r.id) hit = 1'b1;
                        if (hit) begin
                            st = sarf_pkg::ST_OK;
                        end else begin
                            st = sarf_pkg::ST_FULL;
                            for (i = 0; i < ALLOW_N; i++) begin
                                if (st == sarf_pkg::ST_FULL && allow_ids[i] == '0) begin
                                    allow_ids[i] = r.id;
                                    st = sarf_pkg::ST_OK;
                                end
                            end
                        end
                    end
                    sarf_pkg::CMD_REVOKE: begin
                        for (i = 0; i < ALLOW_N; i++) begin
                            if (st == sarf_pkg::ST_DENIED && allow_ids[i] == r.id) begin
                                allow_ids[i] = '0;
                                st = sarf_pkg::ST_OK;
                            end
                        end
                    end
                    default: st = sarf_pkg::ST_DENIED;
                endcase
            end
            verdict_q.push_back(st);
        endfunction

        function void check_verdict(logic ok, logic [1:0] status);
            logic [1:0] st;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTED)
                    $display("ERROR: unexpected result beat ok=%0b status=%0d", ok, status);
            end else begin
                st = verdict_q.pop_front();
                verdict_seen[st]++;
                if (ok !== (st == sarf_pkg::ST_OK) || status !== st) begin
                    errors++;
                    if (errors <= MAX_REPORTED)
                        $display("ERROR: mismatch ok exp=%0b act=%0b, status exp=%0d act=%0d",
                                 st == sarf_pkg::ST_OK, ok, st, status);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    admission_predictor pred = new();
    filter_req_t        stim_q[$];
    logic [31:0]        id_pool[POOL_N];
    logic [31:0]        sim_ms = '0;    // running wall clock for the random phases
    bit                 steady = 1'b0;  // suppress idling on both sides
    int                 settings_used = 0;
    int                 quiet_cycles = 0;

    always #5 aclk = ~aclk;

    sender_allowlist_rate_filter_core #(
        .ALLOW_DEPTH(ALLOW_N),
        .RATE_DEPTH (RATE_N)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] node_id, [63:32] now_ms
        .s_tuser  (s_tuser),   // [1:0] cmd, [2] is_new_report
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] ok, [2:1] status, [7:3] zero
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Input side: hold a pending beat until accepted, otherwise present the next one
    // or idle now and then.
    always @(posedge aclk) begin : feed
        bit gap;
        if (aresetn) begin
            gap = !steady && ($urandom_range(0, 99) < 11);
            if (s_tvalid && s_tready) begin
                pred.note_request(stim_q[0]);
                void'(stim_q.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (stim_q.size() != 0 && !gap) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {stim_q[0].now, stim_q[0].id};
                    s_tuser <= {stim_q[0].fresh, stim_q[0].cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check every accepted beat, stall at random.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                pred.check_verdict(m_tdata[0], m_tdata[2:1]);
            m_tready <= steady || ($urandom_range(0, 99) >= 11);
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_item(input logic [1:0] cmd, input logic [31:0] id,
                              input logic fresh, input logic [31:0] now);
        filter_req_t r;
        r.cmd = cmd;
        r.id = id;
        r.fresh = fresh;
        r.now = now;
        stim_q.push_back(r);
    endtask

    // Block until every queued beat is accepted and every verdict has come back.
    task automatic wait_drained();
        while (stim_q.size() != 0 || pred.pending() != 0)
            @(posedge aclk);
    endtask

    // Write the interval register; call only while the block is idle.
    task automatic set_interval(input logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pred.interval = v;
        settings_used++;
    endtask

    // Mostly well-formed traffic from a small sender pool, with reserved ids,
    // stray ids and unused commands mixed in. With pin_time set, most reports
    // carry the largest time so the rate slots fill with it.
    task automatic queue_random(input int n, input logic [31:0] ivl, input bit pin_time);
        int          k;
        int          roll;
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [31:0] now;
        logic [31:0] span;
        span = (ivl >= 32'h4000_0000) ? 32'hFFFF_FFFF : ivl / 8 + 16;
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 62) cmd = sarf_pkg::CMD_CHECK;
            else if (roll < 82) cmd = sarf_pkg::CMD_ADD;
            else if (roll < 96) cmd = sarf_pkg::CMD_REVOKE;
            else cmd = CMD_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 4) id = '0;
            else if (roll < 9) id = $urandom();
            else id = id_pool[$urandom_range(0, POOL_N - 1)];
            if (pin_time) begin
                roll = $urandom_range(0, 9);
                now = (roll < 7) ? 32'hFFFF_FFFF : (roll == 7) ? 32'h0 : $urandom();
            end else begin
                // advance the clock, with a rare jump anywhere
                if ($urandom_range(0, 99) < 5) sim_ms = $urandom();
                else sim_ms = sim_ms + $urandom_range(0, span);
                now = sim_ms;
            end
            queue_item(cmd, id, $urandom_range(0, 99) < 80, now);
        end
    endtask

    initial begin
        int          k;
        logic [31:0] ivl;
        for (k = 0; k < POOL_N; k++)
            id_pool[k] = $urandom_range(2, 32'hFFFF_FFFF);
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'h1;
        id_pool[2] = 32'h8000_0001;
        id_pool[3] = 32'h8000_0002;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reserved id on every command, unknown sender, double add,
        // old report, accept at time zero, interval edge, wrapped time,
        // full list, revoke. Interval is still the reset value.
        queue_item(sarf_pkg::CMD_CHECK, 32'h0, 1'b1, 32'h0);
        queue_item(sarf_pkg::CMD_ADD, 32'h0, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_REVOKE, 32'h0, 1'b0, 32'h0);
        queue_item(CMD_UNUSED, 32'h0, 1'b1, 32'hFFFF_FFFF);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd100);
        queue_item(sarf_pkg::CMD_REVOKE, 32'hFFFF_FFFF, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'h0);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd10);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd60009);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd60010);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFF0);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'h10);
        queue_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'h0);
        for (k = 1; k < ALLOW_N; k++)
            queue_item(sarf_pkg::CMD_ADD, 32'h8000_0000 | k, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_ADD, 32'h8000_0000 | ALLOW_N, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_REVOKE, 32'hFFFF_FFFF, 1'b0, 32'h0);
        queue_item(sarf_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b0, 32'h0);
        wait_drained();

        // Random phases, each under its own interval setting.
        for (k = 0; k < PHASES; k++) begin
            case (k)
                0: ivl = 32'd0;
                1: ivl = 32'd50;
                2: ivl = 32'd1000;
                3: ivl = 32'hFFFF_FFFF;
                4: ivl = 32'd3;
                5: ivl = $urandom();
                default: ivl = INTERVAL_AT_RESET;
            endcase
            set_interval(ivl);
            steady = (k == 1);
            queue_random(ITEMS_PER_PHASE, ivl, k == 4);
            wait_drained();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d checks, %0d adds, %0d revokes, %0d unused commands, %0d intervals",
                 pred.cmd_seen[sarf_pkg::CMD_CHECK], pred.cmd_seen[sarf_pkg::CMD_ADD],
                 pred.cmd_seen[sarf_pkg::CMD_REVOKE], pred.cmd_seen[CMD_UNUSED],
                 settings_used);
        $display("Verdicts: ok %0d, denied %0d, rate limited %0d, list full %0d; %0d mismatches",
                 pred.verdict_seen[sarf_pkg::ST_OK], pred.verdict_seen[sarf_pkg::ST_DENIED],
                 pred.verdict_seen[sarf_pkg::ST_RATE], pred.verdict_seen[sarf_pkg::ST_FULL],
                 pred.errors);
        if (pred.errors == 0 && pred.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
